/* hw/rtl/lumh_pkg.sv */
// Package: shared types, constants and command/status structs for the luma histogram.
package lumh_pkg;

	localparam int NUM_BINS = 256;
	localparam int BIN_W = $clog2(NUM_BINS);
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int OUT_COUNT_W = 32;
	localparam int LUMA_FRAC = 24;
	localparam int PROD_W = 32;

	localparam logic [23:0] W_RED = 24'd3566836;
	localparam logic [23:0] W_GREEN = 24'd11999066;
	localparam logic [23:0] W_BLUE = 24'd1211315;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_READ = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] read_bin;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  bin;
		logic [31:0] count;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_IDX,
		ST_READ,
		ST_UPD,
		ST_CLR
	} state_t;

	typedef struct packed {
		logic ld_in;
		logic mul;
		logic idx;
		logic rd_mem;
		logic upd;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

/* hw/rtl/lumh_ctrl.sv */
// Controller: sequences one transaction at a time through the datapath.
module lumh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	input  logic [1:0]         pixel_mode,
	input  lumh_pkg::status_t  st,
	output logic               pixel_stall,
	output lumh_pkg::cmd_t     cmd
);

	lumh_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lumh_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lumh_pkg::ST_IDLE: begin
				if (pixel_valid) begin
					case (pixel_mode)
						lumh_pkg::MODE_ADD:   state_nxt = lumh_pkg::ST_MUL;
						lumh_pkg::MODE_CLEAR: state_nxt = lumh_pkg::ST_CLR;
						default:              state_nxt = lumh_pkg::ST_READ;
					endcase
				end
			end
			lumh_pkg::ST_MUL:  state_nxt = lumh_pkg::ST_IDX;
			lumh_pkg::ST_IDX:  state_nxt = lumh_pkg::ST_READ;
			lumh_pkg::ST_READ: state_nxt = lumh_pkg::ST_UPD;
			lumh_pkg::ST_UPD: begin
				if (st.out_free) state_nxt = lumh_pkg::ST_IDLE;
			end
			lumh_pkg::ST_CLR: begin
				if (st.out_free) state_nxt = lumh_pkg::ST_IDLE;
			end
			default: state_nxt = lumh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		pixel_stall = 1'b1;
		case (state_q)
			lumh_pkg::ST_IDLE: begin
				pixel_stall = 1'b0;
				cmd.ld_in = pixel_valid;
			end
			lumh_pkg::ST_MUL:  cmd.mul = 1'b1;
			lumh_pkg::ST_IDX:  cmd.idx = 1'b1;
			lumh_pkg::ST_READ: cmd.rd_mem = 1'b1;
			lumh_pkg::ST_UPD:  cmd.upd = st.out_free;
			lumh_pkg::ST_CLR:  cmd.clr = st.out_free;
			default: ;
		endcase
	end

endmodule

/* hw/rtl/lumh_dp.sv */
// Datapath: luma multiply/sum, bin memory with valid bits, saturating update, result register.
module lumh_dp #(
	parameter int COUNT_WIDTH = lumh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lumh_pkg::in_item_t   pixel,
	input  lumh_pkg::cmd_t       cmd,
	input  logic                 result_stall,
	output lumh_pkg::status_t    st,
	output logic                 result_valid,
	output lumh_pkg::out_item_t  result
);

	localparam int BW = lumh_pkg::BIN_W;

	logic [COUNT_WIDTH-1:0] mem [lumh_pkg::NUM_BINS];
	logic [lumh_pkg::NUM_BINS-1:0] vld_q;

	lumh_pkg::in_item_t in_q;
	logic [lumh_pkg::PROD_W-1:0] prod_r_s1, prod_g_s1, prod_b_s1;
	logic [lumh_pkg::PROD_W-1:0] luma_sum;
	logic [BW-1:0] idx_q;
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic rvld_q;
	logic [COUNT_WIDTH-1:0] cur_cnt, new_cnt;
	logic is_add;
	logic out_valid_q;
	lumh_pkg::out_item_t out_q;

	assign luma_sum = prod_r_s1 + prod_g_s1 + prod_b_s1;
	assign is_add = (in_q.mode == lumh_pkg::MODE_ADD);
	assign cur_cnt = rvld_q ? rdata_q : '0;
	assign new_cnt = (is_add && (cur_cnt != '1)) ? cur_cnt + 1'b1 : cur_cnt;

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			in_q <= pixel;
		end
		if (cmd.mul) begin
			prod_r_s1 <= lumh_pkg::PROD_W'(in_q.red) * lumh_pkg::PROD_W'(lumh_pkg::W_RED);
			prod_g_s1 <= lumh_pkg::PROD_W'(in_q.green) * lumh_pkg::PROD_W'(lumh_pkg::W_GREEN);
			prod_b_s1 <= lumh_pkg::PROD_W'(in_q.blue) * lumh_pkg::PROD_W'(lumh_pkg::W_BLUE);
		end
		if (cmd.ld_in) begin
			idx_q <= BW'(pixel.read_bin);
		end else if (cmd.idx) begin
			idx_q <= BW'(luma_sum >> lumh_pkg::LUMA_FRAC);
		end
		if (cmd.rd_mem) begin
			rdata_q <= mem[idx_q];
		end
		if (cmd.upd && is_add) begin
			mem[idx_q] <= new_cnt;
		end
		if (cmd.upd) begin
			out_q.bin <= 8'(idx_q);
			out_q.count <= lumh_pkg::OUT_COUNT_W'(new_cnt);
		end else if (cmd.clr) begin
			out_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				vld_q <= '0;
			end else if (cmd.upd && is_add) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (cmd.rd_mem) begin
				rvld_q <= vld_q[idx_q];
			end
			if (cmd.upd || cmd.clr) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.out_free = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result = out_q;

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd || cmd.clr) |-> st.out_free)
		else $error("result register loaded while occupied");

	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |=> (vld_q == '0) && out_valid_q)
		else $error("clear did not empty the bins");

	a_bin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> (out_q.bin == 8'($past(idx_q))) && out_valid_q)
		else $error("result bin does not match updated bin");

	a_add_vld: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd && is_add) |=> vld_q[$past(idx_q)])
		else $error("added bin not marked valid");

endmodule

/* hw/rtl/luminance_histogram_top.sv */
// Top level: 256-bin BT.709 luma histogram with add, read and clear transactions.
//
// Input channel pixel/pixel_valid/pixel_stall carries a command (add, read, clear)
// with an RGB pixel or a bin number. Output channel result/result_valid/result_stall
// returns one transaction per command: the bin touched and its count afterwards.
// One command is in flight at a time; pixel_stall is high while it is worked.
// An add passes multiply, sum, memory read and update before its result is valid,
// a read (mode 1 or 3) memory read and update, and a clear loads the result
// directly; the next command is accepted once the controller is back in idle.
// A clear drops all bins at once via their valid bits.
// Counts saturate at the all-ones value of COUNT_WIDTH; the result shows the
// low 32 bits.
// Reset (arst_n low) empties every bin and the result register; the block
// is idle and accepts a command as soon as reset is released.
// A stalled result holds its value; the next command is still accepted but
// waits at its update or clear step until the register frees.
module luminance_histogram_top #(
	parameter int COUNT_WIDTH = lumh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  lumh_pkg::in_item_t   pixel,
	output logic                 result_valid,
	input  logic                 result_stall,
	output lumh_pkg::out_item_t  result
);

	lumh_pkg::cmd_t    cmd;
	lumh_pkg::status_t st;

	lumh_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_mode  (pixel.mode),
		.st          (st),
		.pixel_stall (pixel_stall),
		.cmd         (cmd)
	);

	lumh_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (pixel),
		.cmd          (cmd),
		.result_stall (result_stall),
		.st           (st),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the luma histogram: directed table and random commands.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lumh_pkg::*;

	localparam int COUNT_W = COUNT_WIDTH_DEF;
	localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_AT = 400;
	localparam int HOLD_CYC = 400;
	localparam int RAND_PER_PHASE = 260;
	localparam int DIR_N = 22;

	typedef struct {
		in_item_t  cmd;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      pixel_valid = 1'b0;
	logic      pixel_stall;
	in_item_t  pixel = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	logic [COUNT_W-1:0] hist_model [NUM_BINS];
	logic [7:0]         last_luma_bin = '0;
	out_item_t          bin_results_due [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int n_in = 0;
	int n_out = 0;
	int n_add = 0;
	int n_read = 0;
	int n_clear = 0;
	int errors = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// Expected values typed in where obvious; P rows (typed = 0) come from the predictor.
	dir_row_t dir_rows [DIR_N] = '{
		'{'{MODE_READ,  8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   32'd0}},
		'{'{MODE_READ,  8'd0,   8'd0,   8'd0,   8'd255}, 1'b1, '{8'd255, 32'd0}},
		'{'{MODE_ADD,   8'd0,   8'd0,   8'd0,   8'd255}, 1'b1, '{8'd0,   32'd1}},
		'{'{MODE_ADD,   8'd255, 8'd255, 8'd255, 8'd0  }, 1'b1, '{8'd255, 32'd1}},
		'{'{MODE_ADD,   8'd255, 8'd255, 8'd255, 8'd0  }, 1'b1, '{8'd255, 32'd2}},
		'{'{MODE_ADD,   8'd255, 8'd0,   8'd0,   8'd0  }, 1'b0, '{8'd0,   32'd0}},
		'{'{MODE_ADD,   8'd0,   8'd255, 8'd0,   8'd0  }, 1'b0, '{8'd0,   32'd0}},
		'{'{MODE_ADD,   8'd0,   8'd0,   8'd255, 8'd0  }, 1'b0, '{8'd0,   32'd0}},
		'{'{MODE_ADD,   8'd128, 8'd128, 8'd128, 8'd0  }, 1'b0, '{8'd0,   32'd0}},
		'{'{MODE_ADD,   8'd1,   8'd1,   8'd1,   8'd0  }, 1'b0, '{8'd0,   32'd0}},
		'{'{MODE_ADD,   8'd0,   8'd0,   8'd1,   8'd0  }, 1'b0, '{8'd0,   32'd0}},
		'{'{MODE_READ,  8'd0,   8'd0,   8'd0,   8'd54 }, 1'b0, '{8'd0,   32'd0}},
		'{'{MODE_RSVD,  8'd0,   8'd0,   8'd0,   8'd255}, 1'b1, '{8'd255, 32'd2}},
		'{'{MODE_RSVD,  8'd255, 8'd255, 8'd255, 8'd0  }, 1'b1, '{8'd0,   32'd2}},
		'{'{MODE_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   32'd0}},
		'{'{MODE_READ,  8'd0,   8'd0,   8'd0,   8'd255}, 1'b1, '{8'd255, 32'd0}},
		'{'{MODE_READ,  8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   32'd0}},
		'{'{MODE_ADD,   8'd17,  8'd200, 8'd3,   8'd170}, 1'b0, '{8'd0,   32'd0}},
		'{'{MODE_CLEAR, 8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   32'd0}},
		'{'{MODE_ADD,   8'd254, 8'd254, 8'd254, 8'd85 }, 1'b0, '{8'd0,   32'd0}},
		'{'{MODE_READ,  8'd0,   8'd0,   8'd0,   8'd128}, 1'b1, '{8'd128, 32'd0}},
		'{'{MODE_READ,  8'haa,  8'h55,  8'haa,  8'h55 }, 1'b1, '{8'd85,  32'd0}}
	};

	luminance_histogram_top #(
		.COUNT_WIDTH(COUNT_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic out_item_t histogram_apply(in_item_t cmd);
		longint unsigned luma;
		logic [7:0]      idx;
		out_item_t       res;
		res = '0;
		case (mode_t'(cmd.mode))
			MODE_CLEAR: begin
				foreach (hist_model[i]) hist_model[i] = '0;
			end
			MODE_ADD: begin
				luma = 64'(cmd.red) * 64'(W_RED) + 64'(cmd.green) * 64'(W_GREEN)
					+ 64'(cmd.blue) * 64'(W_BLUE);
				luma = luma >> LUMA_FRAC;
				idx = (luma > NUM_BINS - 1) ? 8'(NUM_BINS - 1) : luma[7:0];
				if (hist_model[idx] != CNT_MAX)
					hist_model[idx] = hist_model[idx] + 1'b1;
				last_luma_bin = idx;
				res.bin = idx;
				res.count = 32'(hist_model[idx]);
			end
			default: begin
				idx = cmd.read_bin;
				res.bin = idx;
				res.count = 32'(hist_model[idx]);
			end
		endcase
		return res;
	endfunction

	function automatic logic [7:0] rand_channel();
		int p;
		p = $urandom_range(99);
		if (p < 10)
			return 8'd0;
		else if (p < 20)
			return 8'd255;
		return 8'($urandom_range(255));
	endfunction

	function automatic in_item_t rand_cmd();
		in_item_t cmd;
		int       p;
		p = $urandom_range(99);
		cmd.mode = (p < 72) ? MODE_ADD : (p < 90) ? MODE_READ : (p < 97) ? MODE_RSVD : MODE_CLEAR;
		cmd.red = rand_channel();
		cmd.green = rand_channel();
		if ($urandom_range(9) == 0)
			cmd.green = cmd.red;
		cmd.blue = rand_channel();
		cmd.read_bin = $urandom_range(1) ? 8'($urandom_range(255)) : last_luma_bin;
		return cmd;
	endfunction

	task automatic apply_cmd(input in_item_t cmd, input bit typed, input out_item_t want);
		int        gap;
		out_item_t pred;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel <= cmd;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		pred = histogram_apply(cmd);
		bin_results_due.push_back(typed ? want : pred);
		n_in <= n_in + 1;
		case (mode_t'(cmd.mode))
			MODE_ADD:   n_add++;
			MODE_CLEAR: n_clear++;
			default:    n_read++;
		endcase
	endtask

	task automatic flag_mismatch(input string what, input out_item_t want, input out_item_t got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s: expected bin %0d count %0d, got bin %0d count %0d",
				$realtime, what, want.bin, want.count, got.bin, got.count);
	endtask

	// receiver: random stall plus one long hold-off to back up the input side
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_in >= HOLD_AT) begin
			result_stall <= 1'b1;
			hold_left <= HOLD_CYC;
			hold_done <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			n_out++;
			if (bin_results_due.size() == 0) begin
				flag_mismatch("unexpected transaction", '0, result);
			end else begin
				want = bin_results_due.pop_front();
				if (result.bin !== want.bin || result.count !== want.count)
					flag_mismatch("result mismatch", want, result);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		foreach (hist_model[i]) hist_model[i] = '0;

		tx_idle_pct = 13;
		rx_idle_pct <= 61;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			apply_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
		repeat (RAND_PER_PHASE) apply_cmd(rand_cmd(), 1'b0, '0);

		tx_idle_pct = 61;
		rx_idle_pct <= 13;
		repeat (RAND_PER_PHASE) apply_cmd(rand_cmd(), 1'b0, '0);

		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		repeat (RAND_PER_PHASE) apply_cmd(rand_cmd(), 1'b0, '0);
		pixel_valid <= 1'b0;

		while (bin_results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d commands (%0d add, %0d read, %0d clear), %0d results checked,",
			n_add + n_read + n_clear, n_add, n_read, n_clear, n_out);
		$display("with sender/receiver idling and a %0d-cycle output hold-off.",
			HOLD_CYC);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
